// ===== hdl/two_class_fifo_oldest_first_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-class oldest-first queue block
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_FIFO_OLDEST_FIRST_TOP_DEFINES_SVH
`define TWO_CLASS_FIFO_OLDEST_FIRST_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge while out of reset.
`define TCF_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define TCF_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`else

`define TCF_ASSERT(name, prop, msg)
`define TCF_ASSERT_RST(name, prop, msg)

`endif

`endif

// ===== hdl/tcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcf_pkg
// Types and constants shared by the two-class oldest-first queue block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcf_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int STAMP_BITS  = 6;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Stream word widths: class bit plus tag, rounded up to whole bytes
    localparam int DATA_W      = ((1 + TAG_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_ENQ     = 2'd0,
        OP_DEQ_ANY = 2'd1,
        OP_DEQ0    = 2'd2,
        OP_DEQ1    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [TAG_BITS-1:0]   tag;
        logic [STAMP_BITS-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_queue_ctrl;

    typedef struct packed {
        logic   empty;
        logic   full;
        t_entry head;
    } t_queue_status;

endpackage

// ===== hdl/tcf_queue.sv =====
// ----------------------------------------------------------------------------
// tcf_queue
// One class queue: circular store of tag/stamp entries with head and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_class_fifo_oldest_first_top_defines.svh"

module tcf_queue
    import tcf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_queue_ctrl   i_ctrl,
    input  t_entry        i_entry,
    output t_queue_status o_status
);

    t_entry           r_store [QUEUE_DEPTH];
    logic [IDX_W-1:0] r_head;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] n_head;
    logic [CNT_W-1:0] n_count;
    logic [IDX_W:0]   w_sum;
    logic [IDX_W-1:0] w_tail;

    // Tail sits count entries past the head, wrapped once
    always_comb begin
        w_sum = {1'b0, r_head} + (IDX_W + 1)'(r_count);
        if (w_sum >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
            w_tail = IDX_W'(w_sum - (IDX_W + 1)'(QUEUE_DEPTH));
        end else begin
            w_tail = IDX_W'(w_sum);
        end
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_ctrl.push) begin
            n_count = r_count + 1'b1;
        end else if (i_ctrl.pop) begin
            n_count = r_count - 1'b1;
            if (r_head == IDX_W'(QUEUE_DEPTH - 1)) begin
                n_head = '0;
            end else begin
                n_head = r_head + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_store[w_tail] <= i_entry;
        end
    end

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.head  = r_store[r_head];

    `TCF_ASSERT(a_no_push_and_pop, !(i_ctrl.push && i_ctrl.pop), "push and pop together")
    `TCF_ASSERT(a_count_bound, r_count <= CNT_W'(QUEUE_DEPTH), "count beyond depth")
    `TCF_ASSERT(a_pop_count, i_ctrl.pop |=> r_count == $past(r_count) - 1'b1, "pop count slip")
    `TCF_ASSERT(a_push_count, i_ctrl.push |=> r_count == $past(r_count) + 1'b1, "push count slip")

endmodule

// ===== hdl/two_class_fifo_oldest_first_top.sv =====
// Path: a word accepted on the slave side enters the input register, then moves to the
// result register, which drives master-side tvalid; a stalled receiver holds the word longer.
// Throughput: one word per cycle while m_axis_tready stays high; each word touches only
// queue heads, one tail write and a single stamp compare between the input and result registers.
// Reset (synchronous, active low) empties both queues and zeros the arrival counter;
// queue storage is not cleared, entries are only read once written.
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first_top
// Two class queues with enqueue, per-class dequeue and oldest-first dequeue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_class_fifo_oldest_first_top_defines.svh"

module two_class_fifo_oldest_first_top
    import tcf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,  // [0] item_class, [16:1] item_tag
    input  logic [1:0]        s_axis_tuser,  // [1:0] opcode
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,  // [0] out_class, [16:1] out_tag
    output logic [1:0]        m_axis_tuser   // [1:0] status
);

    // Input register
    logic                  r_in_valid;
    t_opcode               r_op;
    logic                  r_class;
    logic [TAG_BITS-1:0]   r_tag;

    // Result register
    logic                  r_out_valid;
    t_status               r_status;
    logic                  r_out_class;
    logic [TAG_BITS-1:0]   r_out_tag;

    // Sequence counter that stamps each accepted enqueue
    logic [STAMP_BITS-1:0] r_arrival;
    logic [STAMP_BITS-1:0] n_arrival;

    logic                  w_advance;
    logic                  w_fire;
    t_status               n_status;
    logic                  n_out_class;
    logic [TAG_BITS-1:0]   n_out_tag;
    logic                  w_push0, w_push1, w_pop0, w_pop1;
    logic [STAMP_BITS-1:0] w_diff;

    t_queue_ctrl           w_ctrl0, w_ctrl1;
    t_queue_status         w_st0, w_st1;
    t_entry                w_entry;

    // Result register frees up when empty or when its word is taken
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;

    // Stamp order: class 0 head is older when (s0 - s1) reads negative
    assign w_diff = w_st0.head.stamp - w_st1.head.stamp;

    always_comb begin
        n_status    = ST_OK;
        n_out_class = 1'b0;
        n_out_tag   = '0;
        w_push0     = 1'b0;
        w_push1     = 1'b0;
        w_pop0      = 1'b0;
        w_pop1      = 1'b0;
        unique case (r_op)
            OP_ENQ: begin
                // Refuse on full; queue and counter hold
                if (!r_class) begin
                    if (w_st0.full) n_status = ST_FULL;
                    else            w_push0  = 1'b1;
                end else begin
                    if (w_st1.full) n_status = ST_FULL;
                    else            w_push1  = 1'b1;
                end
            end
            OP_DEQ_ANY: begin
                if (w_st0.empty && w_st1.empty) begin
                    n_status = ST_EMPTY;
                end else if (w_st1.empty) begin
                    w_pop0 = 1'b1;
                end else if (w_st0.empty) begin
                    w_pop1 = 1'b1;
                end else if (w_diff[STAMP_BITS-1]) begin
                    w_pop0 = 1'b1;
                end else begin
                    // Equal stamps go to class 1
                    w_pop1 = 1'b1;
                end
            end
            OP_DEQ0: begin
                if (w_st0.empty) n_status = ST_EMPTY;
                else             w_pop0   = 1'b1;
            end
            OP_DEQ1: begin
                if (w_st1.empty) n_status = ST_EMPTY;
                else             w_pop1   = 1'b1;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
        if (w_pop0) begin
            n_out_tag = w_st0.head.tag;
        end else if (w_pop1) begin
            n_out_class = 1'b1;
            n_out_tag   = w_st1.head.tag;
        end
    end

    // Queue strobes only when the word actually moves into the result register
    assign w_ctrl0.push = w_fire && w_push0;
    assign w_ctrl0.pop  = w_fire && w_pop0;
    assign w_ctrl1.push = w_fire && w_push1;
    assign w_ctrl1.pop  = w_fire && w_pop1;

    assign w_entry.tag   = r_tag;
    assign w_entry.stamp = r_arrival;

    // Advance the stamp on every enqueue that lands
    assign n_arrival = (w_ctrl0.push || w_ctrl1.push) ? r_arrival + 1'b1 : r_arrival;

    tcf_queue u_queue0 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl0),
        .i_entry  (w_entry),
        .o_status (w_st0)
    );

    tcf_queue u_queue1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl1),
        .i_entry  (w_entry),
        .o_status (w_st1)
    );

    // Control: valid flags and the counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_arrival   <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            r_arrival <= n_arrival;
        end
    end

    // Payload: capture on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op    <= t_opcode'(s_axis_tuser);
            r_class <= s_axis_tdata[0];
            r_tag   <= s_axis_tdata[TAG_BITS:1];
        end
        if (w_fire) begin
            r_status    <= n_status;
            r_out_class <= n_out_class;
            r_out_tag   <= n_out_tag;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {{(DATA_W - 1 - TAG_BITS){1'b0}}, r_out_tag, r_out_class};

    `TCF_ASSERT_RST(a_reset_drains, !i_rst_n |=> !m_axis_tvalid && !r_in_valid, "valid after reset")
    `TCF_ASSERT(a_quiet_result, m_axis_tvalid && r_status != ST_OK |-> r_out_tag == '0 && !r_out_class, "tag on non-ok result")
    `TCF_ASSERT(a_stamp_hold, !(w_ctrl0.push || w_ctrl1.push) |=> $stable(r_arrival), "stamp moved without enqueue")
    `TCF_ASSERT(a_pop_nonempty, !(w_ctrl0.pop && w_st0.empty) && !(w_ctrl1.pop && w_st1.empty), "pop of empty queue")
    `TCF_ASSERT(a_one_queue_op, $countones({w_ctrl0.push, w_ctrl0.pop, w_ctrl1.push, w_ctrl1.pop}) <= 1, "several queue strobes")

endmodule

// ===== tb/sv/two_class_fifo_oldest_first_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first_top_test
// Self-checking bench for the dog/cat queue pair with oldest-first dequeue.
// A scoreboard keeps its own pair of class queues with 6-bit arrival stamps
// and predicts the reply word for every accepted request word. Directed words
// cover empty and full queues and tag extremes. Random bursts then fill,
// drain and churn the queues under several idle and stall phases, with one
// long receiver hold-off.
// ----------------------------------------------------------------------------

module two_class_fifo_oldest_first_top_test;
    import tcf_pkg::*;

    // Shape of one predicted reply word
    typedef struct packed {
        t_status               status;
        logic                  cls;
        logic [TAG_BITS-1:0]   tag;
    } t_reply;

    // Kinds of random bursts: mixed traffic, mostly enqueues, mostly dequeues,
    // and one class cycling while the other ages (drives stamp wrap-around)
    typedef enum logic [1:0] {
        BURST_MIX   = 2'd0,
        BURST_FILL  = 2'd1,
        BURST_DRAIN = 2'd2,
        BURST_CHURN = 2'd3
    } t_burst;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror both class queues and the arrival counter, queue up
    // the reply expected for each request, and check replies in order.
    // ------------------------------------------------------------------------
    class oldest_first_scoreboard;
        t_entry                dog_queue[$];
        t_entry                cat_queue[$];
        logic [STAMP_BITS-1:0] arrival_stamp;
        t_reply                pending_replies[$];
        int                    error_count;

        function new();
            arrival_stamp = '0;
            error_count   = 0;
        endfunction

        function int pending_count();
            return pending_replies.size();
        endfunction

        // Apply one accepted request to the mirrored queues and note its reply
        function void note_request(t_opcode op, logic cls, logic [TAG_BITS-1:0] tag);
            t_reply                rep;
            t_entry                slot;
            logic [STAMP_BITS-1:0] gap;
            int                    pick;
            rep.status = ST_OK;
            rep.cls    = 1'b0;
            rep.tag    = '0;
            pick       = -1;
            if (op == OP_ENQ) begin
                // Refuse on a full queue; neither queue nor stamp moves
                if ((cls ? cat_queue.size() : dog_queue.size()) >= QUEUE_DEPTH) begin
                    rep.status = ST_FULL;
                end else begin
                    slot.tag   = tag;
                    slot.stamp = arrival_stamp;
                    if (cls) cat_queue.push_back(slot);
                    else     dog_queue.push_back(slot);
                    arrival_stamp = arrival_stamp + 1'b1;
                end
            end else begin
                if (op == OP_DEQ0) begin
                    pick = (dog_queue.size() != 0) ? 0 : -1;
                end else if (op == OP_DEQ1) begin
                    pick = (cat_queue.size() != 0) ? 1 : -1;
                end else if (dog_queue.size() == 0 && cat_queue.size() == 0) begin
                    pick = -1;
                end else if (cat_queue.size() == 0) begin
                    pick = 0;
                end else if (dog_queue.size() == 0) begin
                    pick = 1;
                end else begin
                    // Modular stamp compare: dog wins only when strictly older,
                    // ties and wrapped-looking gaps go to cat
                    gap  = dog_queue[0].stamp - cat_queue[0].stamp;
                    pick = gap[STAMP_BITS-1] ? 0 : 1;
                end
                if (pick == 0) begin
                    slot    = dog_queue.pop_front();
                    rep.cls = 1'b0;
                    rep.tag = slot.tag;
                end else if (pick == 1) begin
                    slot    = cat_queue.pop_front();
                    rep.cls = 1'b1;
                    rep.tag = slot.tag;
                end else begin
                    rep.status = ST_EMPTY;
                end
            end
            pending_replies.push_back(rep);
        endfunction

        // Compare one accepted reply word with the oldest prediction
        function void check_reply(t_status st, logic cls, logic [TAG_BITS-1:0] tag);
            t_reply want;
            if (pending_replies.size() == 0) begin
                $error("reply with no request waiting: status %0d class %0d tag %h",
                       st, cls, tag);
                error_count++;
                return;
            end
            want = pending_replies.pop_front();
            if (st !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, st);
                error_count++;
            end
            if (cls !== want.cls) begin
                $error("out_class: expected %0d, got %0d", want.cls, cls);
                error_count++;
            end
            if (tag !== want.tag) begin
                $error("out_tag: expected %h, got %h", want.tag, tag);
                error_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;   // [0] item_class, [16:1] item_tag
    logic [1:0]        s_axis_tuser;   // [1:0] opcode
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;   // [0] out_class, [16:1] out_tag
    logic [1:0]        m_axis_tuser;   // [1:0] status

    // Idle and stall knobs, changed per phase by the main sequence
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    // Long receiver hold-off; counted down by the receiver process
    int          recv_hold_cycles;

    oldest_first_scoreboard sb;

    always #5 i_clk = ~i_clk;

    two_class_fifo_oldest_first_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------------
    // Receiver: drive tready at the falling edge. Hold it low for the whole
    // hold-off stretch, otherwise stall at random per the phase setting.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (recv_hold_cycles > 0) begin
            m_axis_tready    <= 1'b0;
            recv_hold_cycles <= recv_hold_cycles - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge. Check the reply
    // first; a reply can never belong to a request taken at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_reply(t_status'(m_axis_tuser), m_axis_tdata[0],
                               m_axis_tdata[TAG_BITS:1]);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(t_opcode'(s_axis_tuser), s_axis_tdata[0],
                                s_axis_tdata[TAG_BITS:1]);
        end
    end

    // Tag with the extremes showing up often
    function automatic logic [TAG_BITS-1:0] pick_tag();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return TAG_BITS'($urandom);
    endfunction

    // Offer one request word: idle at random first, then hold it until taken
    task automatic send_word(input t_opcode op, input logic cls,
                             input logic [TAG_BITS-1:0] tag);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(DATA_W-TAG_BITS-1){1'b0}}, tag, cls};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Pause the sender until every predicted reply has come back
    task automatic drain_replies();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
    endtask

    // Random bursts; on dequeues the class and tag bits are don't-care noise
    task automatic send_random(input int count);
        t_burst      mode;
        int          left;
        logic        churn_cls;
        int unsigned r;
        t_opcode     op;
        logic        cls;
        mode      = BURST_MIX;
        left      = 0;
        churn_cls = 1'b0;
        for (int n = 0; n < count; n++) begin
            if (left == 0) begin
                mode      = t_burst'($urandom_range(3));
                left      = $urandom_range(8, 40);
                churn_cls = 1'($urandom_range(1));
            end
            left--;
            r   = $urandom_range(99);
            cls = 1'($urandom_range(1));
            case (mode)
                BURST_MIX: begin
                    op = t_opcode'($urandom_range(3));
                end
                BURST_FILL: begin
                    op = (r < 75) ? OP_ENQ : t_opcode'($urandom_range(1, 3));
                end
                BURST_DRAIN: begin
                    op = (r < 25) ? OP_ENQ : t_opcode'($urandom_range(1, 3));
                end
                default: begin
                    // Cycle one class so its stamps run ahead of the other head
                    if (n % 2 == 0) begin
                        op  = OP_ENQ;
                        cls = churn_cls;
                    end else if (r < 80) begin
                        op = churn_cls ? OP_DEQ1 : OP_DEQ0;
                    end else begin
                        op = OP_DEQ_ANY;
                    end
                end
            endcase
            send_word(op, cls, pick_tag());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb               = new();
        i_rst_n          = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tuser     = OP_ENQ;
        m_axis_tready    = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        recv_hold_cycles = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every dequeue on empty queues
        send_word(OP_DEQ_ANY, 1'b1, '1);
        send_word(OP_DEQ0, 1'b0, '1);
        send_word(OP_DEQ1, 1'b1, '0);
        // One of each class; oldest-first must take cat first, then dog
        send_word(OP_ENQ, 1'b1, '1);
        send_word(OP_ENQ, 1'b0, '0);
        send_word(OP_DEQ_ANY, 1'b0, '0);
        send_word(OP_DEQ_ANY, 1'b1, '0);
        // Fill the dog queue, then one refused enqueue on the full queue
        for (int k = 0; k < QUEUE_DEPTH; k++)
            send_word(OP_ENQ, 1'b0, pick_tag());
        send_word(OP_ENQ, 1'b0, 16'hA5A5);
        send_word(OP_DEQ1, 1'b0, '0);

        // Phase: no idling, with a long receiver hold-off in the middle
        send_random(80);
        recv_hold_cycles = 80;
        send_random(120);
        drain_replies();

        // Phase: sender idles most of the time
        send_idle_pct  = 66;
        recv_stall_pct = 0;
        send_random(180);
        drain_replies();

        // Phase: receiver stalls most of the time
        send_idle_pct  = 0;
        recv_stall_pct = 66;
        send_random(185);
        drain_replies();

        // Phase: light idling on both sides
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        send_random(185);
        drain_replies();

        // Let any stray reply show up before the verdict
        repeat (20) @(posedge i_clk);
        if (sb.error_count == 0 && sb.pending_count() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
